/* design/dqds_pkg.sv */
// dqds_pkg: shared widths, codes, types and the quadrature step function
// for the dual quadrature decoder with speed measurement.
// No dependencies.
package dqds_pkg;

    localparam int POS_W   = 32;
    localparam int TICK_W  = 16;
    localparam int PHASE_W = 2;
    localparam int STEP_W  = 3;

    localparam logic [TICK_W-1:0] WINDOW_TICKS_RESET = 16'd20;

    // operation codes
    localparam logic OP_PIN  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // distance along the forward Gray sequence 00 -> 01 -> 11 -> 10
    localparam logic [1:0] DIFF_NONE = 2'd0;
    localparam logic [1:0] DIFF_FWD  = 2'd1;
    localparam logic [1:0] DIFF_JUMP = 2'd2;
    localparam logic [1:0] DIFF_REV  = 2'd3;

    typedef logic signed [POS_W-1:0] t_pos;
    typedef logic signed [STEP_W-1:0] t_step;

    typedef struct packed {
        logic               en;
        logic [PHASE_W-1:0] phase;
    } t_chan_evt;

    // Place of a phase in the forward sequence: 00->0, 01->1, 11->2... mapped
    // so that 10 sits at 3 and 11 at 2.
    function automatic logic [1:0] gray_index(input logic [PHASE_W-1:0] ph);
        gray_index = {ph[1], ph[1] ^ ph[0]};
    endfunction

    // Signed count increment for one channel event.
    function automatic t_step step_of(input logic [PHASE_W-1:0] prev,
                                      input logic [PHASE_W-1:0] curr,
                                      input logic               rev);
        logic [1:0] diff;
        diff = gray_index(curr) - gray_index(prev);
        unique case (diff)
            DIFF_NONE: step_of = 3'sd0;
            DIFF_FWD:  step_of = 3'sd1;
            DIFF_REV:  step_of = -3'sd1;
            DIFF_JUMP: step_of = rev ? -3'sd2 : 3'sd2;
            default:   step_of = 3'sd0;
        endcase
    endfunction

endpackage

/* design/dqds_channel.sv */
// dqds_channel: one x4 quadrature channel: last phase, last direction and
// the wrapping position count. Depends on dqds_pkg.
module dqds_channel
    import dqds_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_chan_evt i_evt,
    output t_pos      o_count,
    output t_pos      o_count_next
);

    logic [PHASE_W-1:0] r_prev;
    logic               r_rev;
    t_pos               r_count;
    t_step              w_step;
    t_pos               n_count;

    assign w_step  = step_of(r_prev, i_evt.phase, r_rev);
    assign n_count = r_count + {{(POS_W-STEP_W){w_step[STEP_W-1]}}, w_step};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_rev   <= 1'b0;
            r_count <= '0;
        end else if (i_evt.en) begin
            r_prev  <= i_evt.phase;
            r_count <= n_count;
            // remember the sign of the last nonzero move
            if (w_step != '0) begin
                r_rev <= w_step[STEP_W-1];
            end
        end
    end

    assign o_count      = r_count;
    assign o_count_next = i_evt.en ? n_count : r_count;

endmodule

/* design/dqds_window.sv */
// dqds_window: window length register, tick counter and per-window speed
// for both channels. Depends on dqds_pkg.
module dqds_window
    import dqds_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [TICK_W-1:0] i_cfg_wdata,
    input  logic              i_tick,
    input  t_pos              i_count_one,
    input  t_pos              i_count_two,
    output t_pos              o_rate_one,
    output t_pos              o_rate_two,
    output logic              o_done
);

    logic [TICK_W-1:0] r_window_ticks;
    logic [TICK_W-1:0] r_tick_cnt;
    logic [TICK_W-1:0] n_tick_cnt;
    t_pos              r_start_one;
    t_pos              r_start_two;
    t_pos              r_rate_one;
    t_pos              r_rate_two;
    t_pos              n_rate_one;
    t_pos              n_rate_two;
    logic              w_hit;

    assign n_tick_cnt = r_tick_cnt + 1'b1;
    assign w_hit      = i_tick && (n_tick_cnt == r_window_ticks);
    assign n_rate_one = i_count_one - r_start_one;
    assign n_rate_two = i_count_two - r_start_two;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_ticks <= WINDOW_TICKS_RESET;
        end else if (i_cfg_we) begin
            r_window_ticks <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_cnt  <= '0;
            r_start_one <= '0;
            r_start_two <= '0;
            r_rate_one  <= '0;
            r_rate_two  <= '0;
        end else if (w_hit) begin
            r_tick_cnt  <= '0;
            r_start_one <= i_count_one;
            r_start_two <= i_count_two;
            r_rate_one  <= n_rate_one;
            r_rate_two  <= n_rate_two;
        end else if (i_tick) begin
            r_tick_cnt <= n_tick_cnt;
        end
    end

    assign o_rate_one = w_hit ? n_rate_one : r_rate_one;
    assign o_rate_two = w_hit ? n_rate_two : r_rate_two;
    assign o_done     = w_hit;

endmodule

/* design/dual_quadrature_decoder_speed.sv */
// dual_quadrature_decoder_speed: top level of the two-channel x4 quadrature
// decoder with windowed speed. Depends on dqds_pkg, dqds_channel, dqds_window.
//
// Each input word is either a pin event (operation 0) or a timer tick
// (operation 1). On a pin event every flagged channel compares its new A/B
// phase with the last one: a Gray step forward adds +1, backward -1, a jump
// over both pins adds +2 or -2 following the last nonzero direction (forward
// before any move), and an unchanged phase adds 0; positions are 32-bit and
// wrap. Ticks advance a 16-bit counter; when it reaches window_ticks (reset
// 20, written through i_cfg_we / i_cfg_wdata while idle) the window closes,
// each speed becomes the position change since the previous close and
// o_window_done is 1 for that word. Writing 0 makes a window span 65536
// ticks. Every input word yields exactly one output word showing the state
// after that word. The block has an input register and a result register
// with the decode and add between them: a word shows on the output once it
// moves from the input register into the result register, and one word per
// cycle is sustained while the output is not stalled, since the position and
// tick state update as the word moves into the result register.
// The input side keeps accepting while a result waits as long as the input
// register is empty or can move forward.
module dual_quadrature_decoder_speed
    import dqds_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic [TICK_W-1:0]  i_cfg_wdata,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_operation,
    input  logic [PHASE_W-1:0] i_phase_one,
    input  logic [PHASE_W-1:0] i_phase_two,
    input  logic               i_changed_one,
    input  logic               i_changed_two,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_pos               o_position_one,
    output t_pos               o_position_two,
    output t_pos               o_speed_one,
    output t_pos               o_speed_two,
    output logic               o_window_done
);

    // input register
    logic               r_in_valid;
    logic               r_in_op;
    logic [PHASE_W-1:0] r_in_phase_one;
    logic [PHASE_W-1:0] r_in_phase_two;
    logic               r_in_changed_one;
    logic               r_in_changed_two;

    // result register
    logic r_out_valid;
    t_pos r_out_pos_one;
    t_pos r_out_pos_two;
    t_pos r_out_speed_one;
    t_pos r_out_speed_two;
    logic r_out_done;

    logic      w_adv;
    logic      w_tick;
    t_chan_evt w_evt_one;
    t_chan_evt w_evt_two;
    t_pos      w_count_one;
    t_pos      w_count_two;
    t_pos      w_next_one;
    t_pos      w_next_two;
    t_pos      w_rate_one;
    t_pos      w_rate_two;
    logic      w_done;

    // Move the held word into the result register whenever that slot is
    // free or being drained this cycle.
    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;
    assign w_tick     = w_adv && (r_in_op == OP_TICK);

    assign w_evt_one.en    = w_adv && (r_in_op == OP_PIN) && r_in_changed_one;
    assign w_evt_one.phase = r_in_phase_one;
    assign w_evt_two.en    = w_adv && (r_in_op == OP_PIN) && r_in_changed_two;
    assign w_evt_two.phase = r_in_phase_two;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    // payload: load on accept, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_op          <= i_operation;
            r_in_phase_one   <= i_phase_one;
            r_in_phase_two   <= i_phase_two;
            r_in_changed_one <= i_changed_one;
            r_in_changed_two <= i_changed_two;
        end
    end

    dqds_channel u_chan_one (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_evt        (w_evt_one),
        .o_count      (w_count_one),
        .o_count_next (w_next_one)
    );

    dqds_channel u_chan_two (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_evt        (w_evt_two),
        .o_count      (w_count_two),
        .o_count_next (w_next_two)
    );

    // Positions never move on a tick, so the window sees the held counts.
    dqds_window u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_tick      (w_tick),
        .i_count_one (w_count_one),
        .i_count_two (w_count_two),
        .o_rate_one  (w_rate_one),
        .o_rate_two  (w_rate_two),
        .o_done      (w_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_pos_one   <= w_next_one;
            r_out_pos_two   <= w_next_two;
            r_out_speed_one <= w_rate_one;
            r_out_speed_two <= w_rate_two;
            r_out_done      <= w_done;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_position_one = r_out_pos_one;
    assign o_position_two = r_out_pos_two;
    assign o_speed_one    = r_out_speed_one;
    assign o_speed_two    = r_out_speed_two;
    assign o_window_done  = r_out_done;

`ifndef SYNTHESIS
    // a held word is never dropped while the result side is stalled
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_adv |=> r_in_valid)
        else $error("input word lost while stalled");

    // an empty result register always lets the input side take a word
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_in_ready)
        else $error("input blocked with empty result register");

    // ticks never move the positions
    a_tick_keeps_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tick |=> (w_count_one == $past(w_count_one))
                   && (w_count_two == $past(w_count_two)))
        else $error("position changed on a tick");

    // a pin event never closes a window
    a_pin_no_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && (r_in_op == OP_PIN) |=> !o_window_done)
        else $error("window closed on a pin event");
`endif

endmodule

/* test/dual_quadrature_decoder_speed_test.sv */
`timescale 1ns / 100ps
// Testbench for dual_quadrature_decoder_speed: a scoreboard class that tracks positions,
// headings and window speeds, plus tasks that drive pin-event and tick words.
// Depends on dqds_pkg and the dual_quadrature_decoder_speed RTL.

import dqds_pkg::*;

// Heading of one encoder, as the decoder keeps it for diagonal jumps.
typedef enum logic [1:0] {
    HEAD_NONE = 2'd0,
    HEAD_FWD  = 2'd1,
    HEAD_BACK = 2'd3
} t_heading;

typedef struct packed {
    t_pos position_one;
    t_pos position_two;
    t_pos speed_one;
    t_pos speed_two;
    logic window_done;
} t_result_word;

// Place of each phase along 00 -> 01 -> 11 -> 10; the table is its own inverse.
localparam logic [1:0] GRAY_POS [4] = '{2'd0, 2'd1, 2'd3, 2'd2};
localparam int REPORT_LIMIT = 10;

class decoder_scoreboard;
    logic [TICK_W-1:0]  window_len;
    logic [TICK_W-1:0]  tick_count;
    logic [PHASE_W-1:0] last_one, last_two;
    t_heading           head_one, head_two;
    t_pos               pos_one, pos_two;
    t_pos               mark_one, mark_two;
    t_pos               rate_one, rate_two;
    t_result_word       awaited[$];
    int mismatches, strays, word_count, tick_total, windows_closed;

    function new();
        window_len = WINDOW_TICKS_RESET;
        tick_count = '0;
        last_one = '0;
        last_two = '0;
        head_one = HEAD_NONE;
        head_two = HEAD_NONE;
        pos_one = '0;
        pos_two = '0;
        mark_one = '0;
        mark_two = '0;
        rate_one = '0;
        rate_two = '0;
        mismatches = 0;
        strays = 0;
        word_count = 0;
        tick_total = 0;
        windows_closed = 0;
    endfunction

    function void set_window(input logic [TICK_W-1:0] len);
        window_len = len;
    endfunction

    function t_pos move_of(input logic [PHASE_W-1:0] prev, input logic [PHASE_W-1:0] curr,
                           input t_heading head);
        logic [1:0] gap;
        gap = GRAY_POS[curr] - GRAY_POS[prev];
        case (gap)
            DIFF_FWD:  return 1;
            DIFF_REV:  return -1;
            DIFF_JUMP: return (head == HEAD_BACK) ? -2 : 2;
            default:   return 0;
        endcase
    endfunction

    function void advance(input logic [PHASE_W-1:0] phase, inout logic [PHASE_W-1:0] last,
                          inout t_heading head, inout t_pos pos);
        t_pos step;
        step = move_of(last, phase, head);
        pos = pos + step;
        if (step != 0) head = (step < 0) ? HEAD_BACK : HEAD_FWD;
        last = phase;
    endfunction

    function void note_word(input logic op, input logic [PHASE_W-1:0] p1,
                            input logic [PHASE_W-1:0] p2, input logic c1, input logic c2);
        t_result_word w;
        w.window_done = 1'b0;
        word_count++;
        if (op == OP_PIN) begin
            if (c1) advance(p1, last_one, head_one, pos_one);
            if (c2) advance(p2, last_two, head_two, pos_two);
        end else begin
            tick_total++;
            tick_count = tick_count + 1'b1;
            if (tick_count == window_len) begin
                tick_count = '0;
                rate_one = pos_one - mark_one;
                rate_two = pos_two - mark_two;
                mark_one = pos_one;
                mark_two = pos_two;
                w.window_done = 1'b1;
                windows_closed++;
            end
        end
        w.position_one = pos_one;
        w.position_two = pos_two;
        w.speed_one = rate_one;
        w.speed_two = rate_two;
        awaited.push_back(w);
    endfunction

    function int ticks_into_window();
        return int'(tick_count);
    endfunction

    function int pending();
        return awaited.size();
    endfunction

    function void compare(input string field, input t_pos want, input t_pos got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%s mismatch: expected %0d, got %0d", field, want, got);
        end
    endfunction

    function void check_word(input t_result_word got);
        t_result_word want;
        if (awaited.size() == 0) begin
            strays++;
            if (strays <= REPORT_LIMIT)
                $display("result word with nothing awaited: position_one %0d", got.position_one);
            return;
        end
        want = awaited.pop_front();
        compare("position_one", want.position_one, got.position_one);
        compare("position_two", want.position_two, got.position_two);
        compare("speed_one", want.speed_one, got.speed_one);
        compare("speed_two", want.speed_two, got.speed_two);
        compare("window_done", {31'd0, want.window_done}, {31'd0, got.window_done});
    endfunction

    function int failures();
        return mismatches + strays + awaited.size();
    endfunction
endclass

module dual_quadrature_decoder_speed_test;

    // Abort well past the slowest legal run (about a thousand words, all under long stalls).
    localparam int TIMEOUT_NS = 2_000_000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [TICK_W-1:0]  i_cfg_wdata = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic               i_operation = OP_PIN;
    logic [PHASE_W-1:0] i_phase_one = '0;
    logic [PHASE_W-1:0] i_phase_two = '0;
    logic               i_changed_one = 1'b0;
    logic               i_changed_two = 1'b0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    t_pos               o_position_one, o_position_two;
    t_pos               o_speed_one, o_speed_two;
    logic               o_window_done;

    decoder_scoreboard tracker = new();
    t_result_word      seen_word;

    // Generator state: the last phase sent with its changed flag set, and the
    // direction each encoder mostly turns in.
    logic [PHASE_W-1:0] gen_one = '0;
    logic [PHASE_W-1:0] gen_two = '0;
    t_heading           lean_one = HEAD_FWD;
    t_heading           lean_two = HEAD_FWD;
    int                 burst_left = 0;
    bit                 no_gaps = 1'b0;

    dual_quadrature_decoder_speed dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_phase_one    (i_phase_one),
        .i_phase_two    (i_phase_two),
        .i_changed_one  (i_changed_one),
        .i_changed_two  (i_changed_two),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_position_one (o_position_one),
        .o_position_two (o_position_two),
        .o_speed_one    (o_speed_one),
        .o_speed_two    (o_speed_two),
        .o_window_done  (o_window_done)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Sample both channels at the rising edge. Note the accepted input word first,
    // so a result can never overtake the expectation it belongs to.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                tracker.note_word(i_operation, i_phase_one, i_phase_two,
                                  i_changed_one, i_changed_two);
            if (o_out_valid && i_out_ready) begin
                seen_word.position_one = o_position_one;
                seen_word.position_two = o_position_two;
                seen_word.speed_one = o_speed_one;
                seen_word.speed_two = o_speed_two;
                seen_word.window_done = o_window_done;
                tracker.check_word(seen_word);
            end
        end
    end

    // Receiver: switch at random between stall patterns -
    // always ready, coin flips, mostly ready, periodic, and runs of stalls.
    initial begin : receiver
        int mode, span, period, stall_left;
        stall_left = 0;
        forever begin
            mode = $urandom_range(0, 4);
            span = $urandom_range(20, 200);
            period = $urandom_range(2, 4);
            for (int k = 0; k < span; k++) begin
                @(negedge i_clk);
                case (mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= 1'($urandom_range(0, 1));
                    2: i_out_ready <= ($urandom_range(0, 4) != 0);
                    3: i_out_ready <= ((k % period) == 0);
                    default: begin
                        if (stall_left > 0) begin
                            i_out_ready <= 1'b0;
                            stall_left--;
                        end else begin
                            i_out_ready <= 1'b1;
                            stall_left = $urandom_range(0, 8);
                        end
                    end
                endcase
            end
        end
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("status: fail");
        $finish;
    end

    // Send one word. Called at a falling edge; returns at the falling edge after
    // acceptance with valid still high, so a back-to-back word keeps it high.
    task automatic issue_word(input logic op, input logic [PHASE_W-1:0] p1,
                              input logic [PHASE_W-1:0] p2, input logic c1, input logic c2);
        int gap;
        if (!no_gaps && burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        if (burst_left > 0) burst_left--;
        i_in_valid <= 1'b1;
        i_operation <= op;
        i_phase_one <= p1;
        i_phase_two <= p2;
        i_changed_one <= c1;
        i_changed_two <= c2;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        // Track the phase the decoder now holds for each flagged channel.
        if (op == OP_PIN) begin
            if (c1) gen_one = p1;
            if (c2) gen_two = p2;
        end
    endtask

    // Drop valid and hold off until every awaited result word has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (tracker.pending() != 0);
    endtask

    // Write the window length while the block is idle. With align set, tick
    // first until a window has just closed so a shorter length still closes.
    task automatic write_window(input logic [TICK_W-1:0] len, input bit align);
        if (align)
            while (tracker.ticks_into_window() != 0)
                issue_word(OP_TICK, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        drain_results();
        repeat (4) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= len;
        tracker.set_window(len);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Pick the next phase of one encoder: mostly single steps along its lean,
    // some reversals, diagonal jumps, repeats, and unflagged pin noise.
    task automatic chan_motion(input logic [PHASE_W-1:0] from, inout t_heading lean,
                               output logic [PHASE_W-1:0] ph, output logic chg);
        int pick, delta;
        if ($urandom_range(0, 49) == 0) lean = (lean == HEAD_BACK) ? HEAD_FWD : HEAD_BACK;
        pick = $urandom_range(0, 19);
        chg = 1'b1;
        if (pick < 13) delta = (lean == HEAD_BACK) ? 3 : 1;
        else if (pick < 16) delta = (lean == HEAD_BACK) ? 1 : 3;
        else if (pick < 18) delta = 2;
        else if (pick < 19) delta = 0;
        else begin
            delta = $urandom_range(0, 3);
            chg = 1'b0;
        end
        ph = GRAY_POS[(GRAY_POS[from] + delta) % 4];
    endtask

    task automatic run_random(input int count);
        logic [PHASE_W-1:0] p1, p2;
        logic c1, c2;
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            // Now and then pause the sender until the pipeline is empty.
            if (pick == 0) drain_results();
            if (pick < 30) begin
                issue_word(OP_TICK, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else if (pick < 40) begin
                issue_word(OP_PIN, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else begin
                chan_motion(gen_one, lean_one, p1, c1);
                chan_motion(gen_two, lean_two, p2, c2);
                issue_word(OP_PIN, p1, p2, c1, c2);
            end
        end
    endtask

    // Long tick runs for the widest windows, with a pin event sprinkled in now
    // and then so the closing speeds are not zero.
    task automatic run_long(input int tick_goal);
        logic [PHASE_W-1:0] p1, p2;
        logic c1, c2;
        int ticks;
        ticks = 0;
        while (ticks < tick_goal) begin
            if ($urandom_range(0, 7) == 0) begin
                chan_motion(gen_one, lean_one, p1, c1);
                chan_motion(gen_two, lean_two, p2, c2);
                issue_word(OP_PIN, p1, p2, c1, c2);
            end else begin
                issue_word(OP_TICK, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                ticks++;
            end
        end
    endtask

    initial begin : stimulus
        logic [TICK_W-1:0] phase_lens [5];
        int waited;
        phase_lens = '{16'd1, 16'd2, 16'd3, 16'd7, 16'd0};
        phase_lens[4] = 16'($urandom_range(4, 40));

        // Hold reset low from the start, release it at a falling edge.
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed words under the reset window length. Channel one jumps before
        // any move (counts forward), then walks forward, reverses and jumps
        // backward; channel two starts with a repeat, goes backward and jumps
        // backward, then turns forward and jumps forward.
        issue_word(OP_PIN, 2'b11, 2'b00, 1'b1, 1'b1);
        issue_word(OP_PIN, 2'b10, 2'b10, 1'b1, 1'b1);
        issue_word(OP_PIN, 2'b00, 2'b01, 1'b1, 1'b1);
        issue_word(OP_PIN, 2'b01, 2'b00, 1'b1, 1'b1);
        issue_word(OP_PIN, 2'b00, 2'b11, 1'b1, 1'b1);
        issue_word(OP_PIN, 2'b11, 2'b01, 1'b1, 1'b1);
        // Unflagged channels: new phases must be ignored.
        issue_word(OP_PIN, 2'b00, 2'b10, 1'b0, 1'b0);
        issue_word(OP_PIN, 2'b10, 2'b11, 1'b1, 1'b1);
        issue_word(OP_PIN, 2'b01, 2'b00, 1'b1, 1'b1);
        issue_word(OP_PIN, 2'b01, 2'b11, 1'b1, 1'b0);
        // Ticks ignore the phase and changed fields, set or clear.
        issue_word(OP_TICK, 2'b11, 2'b11, 1'b1, 1'b1);
        issue_word(OP_TICK, 2'b00, 2'b00, 1'b0, 1'b0);
        issue_word(OP_PIN, 2'b11, 2'b00, 1'b1, 1'b1);
        for (int n = 0; n < 8; n++)
            issue_word(OP_TICK, n[1:0], ~n[1:0], n[0], ~n[0]);

        // Random traffic under the reset window, then under several lengths
        // including the shortest one.
        run_random(100);
        foreach (phase_lens[i]) begin
            write_window(phase_lens[i], 1'b1);
            run_random(100);
        end

        // Widest windows at full sender rate. Lower the length to zero while the
        // counter stands at 30: it must run on past the old length without
        // closing. Then set the longest legal length without clearing the counter.
        no_gaps = 1'b1;
        write_window(16'd40, 1'b1);
        run_long(30);
        write_window(16'd0, 1'b0);
        run_long(100);
        write_window(16'hFFFF, 1'b0);
        run_long(100);
        no_gaps = 1'b0;

        // Wait out the remaining results, then wait on for strays.
        i_in_valid <= 1'b0;
        waited = 0;
        while (tracker.pending() != 0 && waited < 2000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);

        $display("covered %0d words: %0d timer ticks and %0d pin events",
                 tracker.word_count, tracker.tick_total,
                 tracker.word_count - tracker.tick_total);
        $display("closed %0d speed windows over lengths 1 to 40 and 20; zero and 65535 held open",
                 tracker.windows_closed);
        if (tracker.failures() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
